/* src/rvx_pkg.sv */
package rvx_pkg;

	localparam logic [2:0] OP_LOAD    = 3'd0;
	localparam logic [2:0] OP_RESTART = 3'd1;
	localparam logic [2:0] OP_STEP    = 3'd2;
	localparam logic [2:0] OP_RDREG   = 3'd3;
	localparam logic [2:0] OP_RDMEM   = 3'd4;

	localparam logic [2:0] ST_RUN   = 3'd0;
	localparam logic [2:0] ST_ECALL = 3'd1;
	localparam logic [2:0] ST_BADOP = 3'd2;
	localparam logic [2:0] ST_PCOUT = 3'd3;
	localparam logic [2:0] ST_LIMIT = 3'd4;

	localparam logic [6:0] OPC_REG    = 7'h33;
	localparam logic [6:0] OPC_IMM    = 7'h13;
	localparam logic [6:0] OPC_LOAD   = 7'h03;
	localparam logic [6:0] OPC_STORE  = 7'h23;
	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_LUI    = 7'h37;
	localparam logic [6:0] OPC_AUIPC  = 7'h17;
	localparam logic [6:0] OPC_JAL    = 7'h6F;
	localparam logic [6:0] OPC_JALR   = 7'h67;
	localparam logic [6:0] OPC_SYSTEM = 7'h73;

	localparam logic [6:0] FUNCT7_ALT = 7'h20;

	localparam logic [1:0] CFG_CODE_BYTES = 2'd0;
	localparam logic [1:0] CFG_INIT_SP    = 2'd1;
	localparam logic [1:0] CFG_STEP_LIMIT = 2'd2;

	typedef struct packed {
		logic        wr;
		logic [31:0] addr;
		logic [31:0] wdata;
		logic [3:0]  be;
	} mem_req_t;

	typedef struct packed {
		logic        clr;
		logic        we;
		logic [4:0]  waddr;
		logic [31:0] wdata;
		logic [4:0]  raddr_a;
		logic [4:0]  raddr_b;
	} rf_req_t;

endpackage

/* src/rvx_ram.sv */
module rvx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* src/rvx_mem.sv */
module rvx_mem import rvx_pkg::*; #(
	parameter int MEM_BYTES = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  mem_req_t    req,
	output logic [31:0] rdata,
	output logic        clearing
);

	localparam int AW = $clog2(MEM_BYTES);
	localparam int RW = AW - 2;
	localparam int ROWS = MEM_BYTES / 4;

	logic [AW-1:0] base;
	logic [1:0]    lo_q;
	logic [RW-1:0] cnt_q;
	logic          clr_q;
	logic [7:0]    dout [4];

	assign base = req.addr[AW-1:0];
	assign clearing = clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= 1'b1;
			cnt_q <= '0;
		end else if (clr_q) begin
			cnt_q <= cnt_q + RW'(1);
			if (cnt_q == RW'(ROWS - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		lo_q <= base[1:0];
	end

	for (genvar k = 0; k < 4; k++) begin : g_bank
		logic [1:0]    off;
		logic [AW-1:0] addr_k;
		logic [RW-1:0] row;
		logic          we;
		logic [7:0]    wbyte;

		assign off = 2'(k) - base[1:0];
		assign addr_k = base + AW'(off);
		assign row = addr_k[AW-1:2];
		assign we = clr_q | (req.wr & req.be[off]);
		assign wbyte = clr_q ? 8'h00 : req.wdata[{off, 3'b000} +: 8];

		rvx_ram #(.WIDTH(8), .DEPTH(ROWS)) u_bank (
			.clk   (clk),
			.we    (we),
			.waddr (clr_q ? cnt_q : row),
			.wdata (wbyte),
			.raddr (row),
			.rdata (dout[k])
		);
	end

	for (genvar i = 0; i < 4; i++) begin : g_asm
		logic [1:0] sel;
		assign sel = lo_q + 2'(i);
		assign rdata[8*i +: 8] = dout[sel];
	end

endmodule

/* src/rvx_rf.sv */
module rvx_rf import rvx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  rf_req_t     req,
	output logic [31:0] rdata_a,
	output logic [31:0] rdata_b
);

	logic [31:0] valid_q;
	logic [31:0] valid_d;
	logic        va_q;
	logic        vb_q;
	logic        we;
	logic [31:0] da;
	logic [31:0] db;

	assign we = req.we & (req.waddr != 5'd0);

	always_comb begin
		valid_d = req.clr ? 32'd0 : valid_q;
		if (we) begin
			valid_d[req.waddr] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			va_q <= 1'b0;
			vb_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
			va_q <= valid_q[req.raddr_a];
			vb_q <= valid_q[req.raddr_b];
		end
	end

	rvx_ram #(.WIDTH(32), .DEPTH(32)) u_bank_a (
		.clk   (clk),
		.we    (we),
		.waddr (req.waddr),
		.wdata (req.wdata),
		.raddr (req.raddr_a),
		.rdata (da)
	);

	rvx_ram #(.WIDTH(32), .DEPTH(32)) u_bank_b (
		.clk   (clk),
		.we    (we),
		.waddr (req.waddr),
		.wdata (req.wdata),
		.raddr (req.raddr_b),
		.rdata (db)
	);

	assign rdata_a = va_q ? da : 32'd0;
	assign rdata_b = vb_q ? db : 32'd0;

endmodule

/* src/rv32i_instruction_executor_top.sv */
// RV32I core driven by commands: load word, restart, step, read register,
// read memory word. After reset busy stays high while the byte memory is
// swept to zero. A step passes through fetch, register read and execute; a
// load adds a data read from the byte-banked memory. A step stopped by the
// step limit or the code limit, or one that finds the core halted, fetches
// nothing and raises done straight from idle, as do load word and restart;
// register and memory reads pass through a read state first. Each result is
// shown for one cycle with done high and must be taken then: the receiver
// cannot stall the block.
module rv32i_instruction_executor_top import rvx_pkg::*; #(
	parameter int MEM_BYTES = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  op,
	input  logic [15:0] mem_address,
	input  logic [31:0] write_data,
	input  logic [4:0]  reg_index,
	output logic        done,
	output logic [2:0]  status,
	output logic [31:0] pc_now,
	output logic [31:0] instruction,
	output logic        dest_written,
	output logic [4:0]  dest_index,
	output logic [31:0] dest_value,
	output logic [31:0] read_data,
	output logic [31:0] step_count,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_DEC  = 6'b000010,
		S_EXE  = 6'b000100,
		S_LD   = 6'b001000,
		S_RREG = 6'b010000,
		S_RMEM = 6'b100000
	} state_t;

	state_t      state_q;
	logic [16:0] code_q;
	logic [31:0] sp_q;
	logic [31:0] limit_q;
	logic [31:0] pc_q;
	logic [31:0] steps_q;
	logic [2:0]  halt_q;
	logic [31:0] insn_q;
	logic        done_q;
	logic [31:0] insn_o_q;
	logic        dw_q;
	logic [4:0]  di_q;
	logic [31:0] dv_q;
	logic [31:0] rdata_q;
	logic [2:0]  lf3_q;
	logic [4:0]  lrd_q;

	mem_req_t    mreq;
	rf_req_t     rreq;
	logic [31:0] mrdata;
	logic        clearing;
	logic [31:0] ra;
	logic [31:0] rb;
	logic        accept;

	logic [6:0]  opc;
	logic [2:0]  f3;
	logic [4:0]  rd;
	logic        alt;
	logic [31:0] imm_i;
	logic [31:0] imm_s;
	logic [31:0] imm_b;
	logic [31:0] imm_j;
	logic [31:0] imm_u;
	logic [31:0] opb;
	logic [31:0] alu;
	logic        take;
	logic [31:0] next_pc;
	logic        wr;
	logic [31:0] val;
	logic        is_ld;
	logic [2:0]  new_halt;
	logic [31:0] ld_val;

	assign accept = start & ~busy;
	assign busy = (state_q != S_IDLE) | clearing;
	assign pready = 1'b1;

	always_comb begin
		case (paddr[3:2])
			CFG_CODE_BYTES: prdata = {15'd0, code_q};
			CFG_INIT_SP:    prdata = sp_q;
			CFG_STEP_LIMIT: prdata = limit_q;
			default:        prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_q <= '0;
			sp_q <= '0;
			limit_q <= 32'd1000000;
		end else if (psel & penable & pwrite) begin
			case (paddr[3:2])
				CFG_CODE_BYTES: code_q <= pwdata[16:0];
				CFG_INIT_SP:    sp_q <= pwdata;
				CFG_STEP_LIMIT: limit_q <= pwdata;
				default: ;
			endcase
		end
	end

	// decode and execute
	always_comb begin
		opc = insn_q[6:0];
		rd = insn_q[11:7];
		f3 = insn_q[14:12];
		alt = insn_q[31:25] == FUNCT7_ALT;
		imm_i = {{20{insn_q[31]}}, insn_q[31:20]};
		imm_s = {{20{insn_q[31]}}, insn_q[31:25], insn_q[11:7]};
		imm_b = {{19{insn_q[31]}}, insn_q[31], insn_q[7], insn_q[30:25], insn_q[11:8], 1'b0};
		imm_j = {{11{insn_q[31]}}, insn_q[31], insn_q[19:12], insn_q[20], insn_q[30:21],
			1'b0};
		imm_u = {insn_q[31:12], 12'd0};
		opb = (opc == OPC_REG) ? rb : imm_i;
		case (f3)
			3'd0:    alu = (opc == OPC_REG && alt) ? ra - opb : ra + opb;
			3'd1:    alu = ra << opb[4:0];
			3'd2:    alu = {31'd0, $signed(ra) < $signed(opb)};
			3'd3:    alu = {31'd0, ra < opb};
			3'd4:    alu = ra ^ opb;
			3'd5:    alu = alt ? 32'($signed(ra) >>> opb[4:0]) : ra >> opb[4:0];
			3'd6:    alu = ra | opb;
			default: alu = ra & opb;
		endcase
		case (f3)
			3'd0:    take = ra == rb;
			3'd1:    take = ra != rb;
			3'd4:    take = $signed(ra) < $signed(rb);
			3'd5:    take = $signed(ra) >= $signed(rb);
			3'd6:    take = ra < rb;
			3'd7:    take = ra >= rb;
			default: take = 1'b0;
		endcase
		next_pc = pc_q + 32'd4;
		wr = 1'b0;
		val = 32'd0;
		is_ld = 1'b0;
		new_halt = halt_q;
		case (opc)
			OPC_REG, OPC_IMM: begin
				wr = 1'b1;
				val = alu;
			end
			OPC_LOAD: is_ld = f3 inside {3'd0, 3'd1, 3'd2, 3'd4, 3'd5};
			OPC_STORE: ;
			OPC_BRANCH: begin
				if (take) begin
					next_pc = pc_q + imm_b;
				end
			end
			OPC_LUI: begin
				wr = 1'b1;
				val = imm_u;
			end
			OPC_AUIPC: begin
				wr = 1'b1;
				val = pc_q + imm_u;
			end
			OPC_JAL: begin
				wr = 1'b1;
				val = pc_q + 32'd4;
				next_pc = pc_q + imm_j;
			end
			OPC_JALR: begin
				wr = 1'b1;
				val = pc_q + 32'd4;
				next_pc = (ra + imm_i) & ~32'd1;
			end
			OPC_SYSTEM: begin
				if (insn_q[31:21] == 11'd0) begin
					new_halt = ST_ECALL;
				end
			end
			default: new_halt = ST_BADOP;
		endcase
		case (lf3_q)
			3'd0:    ld_val = {{24{mrdata[7]}}, mrdata[7:0]};
			3'd1:    ld_val = {{16{mrdata[15]}}, mrdata[15:0]};
			3'd4:    ld_val = {24'd0, mrdata[7:0]};
			3'd5:    ld_val = {16'd0, mrdata[15:0]};
			default: ld_val = mrdata;
		endcase
	end

	always_comb begin
		mreq = '0;
		mreq.addr = pc_q;
		rreq = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (op)
						OP_LOAD, OP_RDMEM: begin
							mreq.addr = {16'd0, mem_address};
							mreq.wr = op == OP_LOAD;
							mreq.wdata = write_data;
							mreq.be = 4'hF;
						end
						OP_RESTART: begin
							rreq.clr = 1'b1;
							rreq.we = 1'b1;
							rreq.waddr = 5'd2;
							rreq.wdata = sp_q;
						end
						OP_RDREG: rreq.raddr_a = reg_index;
						default: ;
					endcase
				end
			end
			S_DEC: begin
				rreq.raddr_a = mrdata[19:15];
				rreq.raddr_b = mrdata[24:20];
			end
			S_EXE: begin
				mreq.addr = ra + ((opc == OPC_STORE) ? imm_s : imm_i);
				mreq.wdata = rb;
				mreq.wr = opc == OPC_STORE;
				case (f3)
					3'd0:    mreq.be = 4'h1;
					3'd1:    mreq.be = 4'h3;
					3'd2:    mreq.be = 4'hF;
					default: mreq.be = 4'h0;
				endcase
				rreq.we = wr;
				rreq.waddr = rd;
				rreq.wdata = val;
			end
			S_LD: begin
				rreq.we = 1'b1;
				rreq.waddr = lrd_q;
				rreq.wdata = ld_val;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q <= '0;
			steps_q <= '0;
			halt_q <= ST_RUN;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (op)
							OP_RESTART: begin
								pc_q <= '0;
								steps_q <= '0;
								halt_q <= ST_RUN;
								done_q <= 1'b1;
							end
							OP_RDREG: state_q <= S_RREG;
							OP_RDMEM: state_q <= S_RMEM;
							OP_STEP: begin
								if (halt_q != ST_RUN) begin
									done_q <= 1'b1;
								end else if (steps_q >= limit_q) begin
									halt_q <= ST_LIMIT;
									done_q <= 1'b1;
								end else if (pc_q >= {15'd0, code_q}) begin
									halt_q <= ST_PCOUT;
									done_q <= 1'b1;
								end else begin
									state_q <= S_DEC;
								end
							end
							default: done_q <= 1'b1;
						endcase
					end
				end
				S_DEC: state_q <= S_EXE;
				S_EXE: begin
					pc_q <= next_pc;
					steps_q <= steps_q + 32'd1;
					halt_q <= new_halt;
					if (is_ld) begin
						state_q <= S_LD;
					end else begin
						state_q <= S_IDLE;
						done_q <= 1'b1;
					end
				end
				S_LD: begin
					state_q <= S_IDLE;
					done_q <= 1'b1;
				end
				S_RREG, S_RMEM: begin
					state_q <= S_IDLE;
					done_q <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					insn_o_q <= '0;
					dw_q <= 1'b0;
					di_q <= '0;
					dv_q <= '0;
					rdata_q <= '0;
				end
			end
			S_DEC: begin
				insn_q <= mrdata;
				insn_o_q <= mrdata;
			end
			S_EXE: begin
				lf3_q <= f3;
				lrd_q <= rd;
				if (wr && rd != 5'd0) begin
					dw_q <= 1'b1;
					di_q <= rd;
					dv_q <= val;
				end
			end
			S_LD: begin
				if (lrd_q != 5'd0) begin
					dw_q <= 1'b1;
					di_q <= lrd_q;
					dv_q <= ld_val;
				end
			end
			S_RREG: rdata_q <= ra;
			S_RMEM: rdata_q <= mrdata;
			default: ;
		endcase
	end

	rvx_mem #(.MEM_BYTES(MEM_BYTES)) u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (mreq),
		.rdata    (mrdata),
		.clearing (clearing)
	);

	rvx_rf u_rf (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (rreq),
		.rdata_a (ra),
		.rdata_b (rb)
	);

	assign done = done_q;
	assign status = halt_q;
	assign pc_now = pc_q;
	assign step_count = steps_q;
	assign instruction = insn_o_q;
	assign dest_written = dw_q;
	assign dest_index = di_q;
	assign dest_value = dv_q;
	assign read_data = rdata_q;

endmodule

/* verif/rv32i_instruction_executor_top_test.sv */
module rv32i_instruction_executor_top_test import rvx_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] pc_now;
		logic [31:0] instruction;
		logic        dest_written;
		logic [4:0]  dest_index;
		logic [31:0] dest_value;
		logic [31:0] read_data;
		logic [31:0] step_count;
	} core_result_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  op;
	logic [15:0] mem_address;
	logic [31:0] write_data;
	logic [4:0]  reg_index;
	logic        done;
	logic [2:0]  status;
	logic [31:0] pc_now;
	logic [31:0] instruction;
	logic        dest_written;
	logic [4:0]  dest_index;
	logic [31:0] dest_value;
	logic [31:0] read_data;
	logic [31:0] step_count;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// core state as the testbench sees it
	logic [7:0]  mem_img [0:65535];
	logic [31:0] gpr [0:31];
	logic [31:0] pc_m;
	logic [31:0] steps_m;
	logic [2:0]  halt_m;
	logic [16:0] code_bytes_m;
	logic [31:0] init_sp_m;
	logic [31:0] step_limit_m;

	core_result_t expected_q [$];
	int errors;
	int cycles;
	int sent;

	rv32i_instruction_executor_top u_dut (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("rv32i_instruction_executor_top_test: FAIL");
			$finish;
		end
	end

	function automatic void cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %h, got %h", name, exp_v, act_v);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		core_result_t e;
		if (arst_n && done) begin
			if (expected_q.size() == 0) begin
				$error("result transfer with nothing expected");
				errors++;
			end else begin
				e = expected_q.pop_front();
				cmp("status", 32'(e.status), 32'(status));
				cmp("pc_now", e.pc_now, pc_now);
				cmp("instruction", e.instruction, instruction);
				cmp("dest_written", 32'(e.dest_written), 32'(dest_written));
				cmp("dest_index", 32'(e.dest_index), 32'(dest_index));
				cmp("dest_value", e.dest_value, dest_value);
				cmp("read_data", e.read_data, read_data);
				cmp("step_count", e.step_count, step_count);
			end
		end
	end

	function automatic logic [31:0] rd8(logic [31:0] a);
		return {24'd0, mem_img[a[15:0]]};
	endfunction

	function automatic logic [31:0] rd16(logic [31:0] a);
		return rd8(a) | (rd8(a + 1) << 8);
	endfunction

	function automatic logic [31:0] rd32(logic [31:0] a);
		return rd16(a) | (rd16(a + 2) << 16);
	endfunction

	function automatic void wr_bytes(logic [31:0] a, logic [31:0] v, int n);
		for (int i = 0; i < n; i++)
			mem_img[16'(a + i)] = v[8*i +: 8];
	endfunction

	function automatic void execute_step(ref core_result_t r);
		logic [31:0] insn, a, b, opnd, val, nxt, ad, imm_i, imm_s, imm_b, imm_j, m;
		logic [6:0]  opc;
		logic [4:0]  rd;
		logic [2:0]  f3;
		logic        alt, wr, take;
		insn  = rd32(pc_m);
		opc   = insn[6:0];
		rd    = insn[11:7];
		f3    = insn[14:12];
		a     = gpr[insn[19:15]];
		b     = gpr[insn[24:20]];
		alt   = insn[31:25] == FUNCT7_ALT;
		imm_i = {{20{insn[31]}}, insn[31:20]};
		imm_s = {{20{insn[31]}}, insn[31:25], insn[11:7]};
		imm_b = {{19{insn[31]}}, insn[31], insn[7], insn[30:25], insn[11:8], 1'b0};
		imm_j = {{11{insn[31]}}, insn[31], insn[19:12], insn[20], insn[30:21], 1'b0};
		nxt   = pc_m + 4;
		val   = '0;
		wr    = 1'b0;
		take  = 1'b0;
		r.instruction = insn;
		case (opc)
			OPC_REG, OPC_IMM: begin
				opnd = (opc == OPC_REG) ? b : imm_i;
				wr = 1'b1;
				case (f3)
					3'd0: val = (opc == OPC_REG && alt) ? a - opnd : a + opnd;
					3'd1: val = a << opnd[4:0];
					3'd2: val = {31'd0, $signed(a) < $signed(opnd)};
					3'd3: val = {31'd0, a < opnd};
					3'd4: val = a ^ opnd;
					3'd5: val = alt ? 32'($signed(a) >>> opnd[4:0]) : a >> opnd[4:0];
					3'd6: val = a | opnd;
					default: val = a & opnd;
				endcase
			end
			OPC_LOAD: begin
				ad = a + imm_i;
				wr = 1'b1;
				case (f3)
					3'd0: begin
						m = rd8(ad);
						val = {{24{m[7]}}, m[7:0]};
					end
					3'd1: begin
						m = rd16(ad);
						val = {{16{m[15]}}, m[15:0]};
					end
					3'd2: val = rd32(ad);
					3'd4: val = rd8(ad);
					3'd5: val = rd16(ad);
					default: wr = 1'b0;
				endcase
			end
			OPC_STORE: begin
				ad = a + imm_s;
				if (f3 == 3'd0) wr_bytes(ad, b, 1);
				else if (f3 == 3'd1) wr_bytes(ad, b, 2);
				else if (f3 == 3'd2) wr_bytes(ad, b, 4);
			end
			OPC_BRANCH: begin
				case (f3)
					3'd0: take = a == b;
					3'd1: take = a != b;
					3'd4: take = $signed(a) < $signed(b);
					3'd5: take = !($signed(a) < $signed(b));
					3'd6: take = a < b;
					3'd7: take = a >= b;
					default: take = 1'b0;
				endcase
				if (take) nxt = pc_m + imm_b;
			end
			OPC_LUI: begin
				wr = 1'b1;
				val = {insn[31:12], 12'd0};
			end
			OPC_AUIPC: begin
				wr = 1'b1;
				val = pc_m + {insn[31:12], 12'd0};
			end
			OPC_JAL: begin
				wr = 1'b1;
				val = nxt;
				nxt = pc_m + imm_j;
			end
			OPC_JALR: begin
				wr = 1'b1;
				val = nxt;
				nxt = (a + imm_i) & ~32'd1;
			end
			OPC_SYSTEM: if (insn[31:20] <= 12'd1) halt_m = ST_ECALL;
			default: halt_m = ST_BADOP;
		endcase
		if (wr && rd != 0) begin
			gpr[rd] = val;
			r.dest_written = 1'b1;
			r.dest_index = rd;
			r.dest_value = val;
		end
		pc_m = nxt;
		steps_m++;
	endfunction

	function automatic void predict(logic [2:0] cmd, logic [15:0] ma, logic [31:0] wd,
			logic [4:0] ri);
		core_result_t r;
		r = '0;
		case (cmd)
			OP_LOAD: wr_bytes({16'd0, ma}, wd, 4);
			OP_RESTART: begin
				foreach (gpr[i]) gpr[i] = '0;
				gpr[2] = init_sp_m;
				pc_m = '0;
				steps_m = '0;
				halt_m = ST_RUN;
			end
			OP_RDREG: r.read_data = gpr[ri];
			OP_RDMEM: r.read_data = rd32({16'd0, ma});
			OP_STEP: if (halt_m == ST_RUN) begin
				if (steps_m >= step_limit_m) halt_m = ST_LIMIT;
				else if (pc_m >= {15'd0, code_bytes_m}) halt_m = ST_PCOUT;
				else execute_step(r);
			end
			default: ;
		endcase
		r.status = halt_m;
		r.pc_now = pc_m;
		r.step_count = steps_m;
		expected_q.insert(expected_q.size(), r);
	endfunction

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 65) return 0;
		if (p < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_cmd(logic [2:0] cmd, logic [15:0] ma = '0, logic [31:0] wd = '0,
			logic [4:0] ri = '0);
		int g;
		@(negedge clk);
		start = 1'b1;
		op = cmd;
		mem_address = ma;
		write_data = wd;
		reg_index = ri;
		do @(posedge clk); while (busy);
		predict(cmd, ma, wd, ri);
		sent++;
		g = gap_len();
		if (g > 0) begin
			@(negedge clk);
			start = 1'b0;
			repeat (g - 1) @(negedge clk);
		end
	endtask

	task automatic wait_idle();
		@(negedge clk);
		start = 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic cfg_write(logic [1:0] idx, logic [31:0] v);
		wait_idle();
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = v;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			CFG_CODE_BYTES: code_bytes_m = v[16:0];
			CFG_INIT_SP: init_sp_m = v;
			default: step_limit_m = v;
		endcase
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	function automatic logic [4:0] pick_reg();
		return ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 7));
	endfunction

	function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
			logic [4:0] rd, logic [6:0] opc);
		return {imm, rs1, f3, rd, opc};
	endfunction

	function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
			logic [2:0] f3, logic [4:0] rd);
		return {f7, rs2, rs1, f3, rd, OPC_REG};
	endfunction

	function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
			logic [2:0] f3);
		return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
	endfunction

	function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
			logic [2:0] f3);
		return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
	endfunction

	function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
		return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
	endfunction

	function automatic logic [31:0] rand_insn();
		logic [6:0] f7;
		f7 = ($urandom_range(0, 1) != 0) ? FUNCT7_ALT : 7'($urandom_range(0, 127));
		case ($urandom_range(0, 15))
			0, 1, 2: return enc_r(f7, pick_reg(), pick_reg(), 3'($urandom), pick_reg());
			3, 4, 5: return {f7, 5'($urandom), pick_reg(), 3'($urandom), pick_reg(), OPC_IMM};
			6: return enc_i(12'($urandom), pick_reg(), 3'($urandom), pick_reg(), OPC_LOAD);
			7: return enc_s(12'($urandom), pick_reg(), pick_reg(), 3'($urandom));
			8, 9: return enc_b(13'($signed($urandom_range(0, 12)) - 4) << 2, pick_reg(),
					pick_reg(), 3'($urandom));
			10: return {20'($urandom), pick_reg(), OPC_LUI};
			11: return {20'($urandom), pick_reg(), OPC_AUIPC};
			12: return enc_j(21'($signed($urandom_range(0, 8)) - 2) << 2, pick_reg());
			13: return enc_i(12'($urandom_range(0, 40)), pick_reg(), 3'd0, pick_reg(), OPC_JALR);
			14: return {11'd0, 1'($urandom), 13'd0, OPC_SYSTEM} |
					(($urandom_range(0, 3) == 0) ? 32'($urandom) & 32'hFFFFFF80 : 32'd0);
			default: return $urandom;
		endcase
	endfunction

	task automatic load_program(logic [31:0] words [$]);
		foreach (words[i]) send_cmd(OP_LOAD, 16'(4 * i), words[i]);
		cfg_write(CFG_CODE_BYTES, 32'(4 * words.size()));
		send_cmd(OP_RESTART);
	endtask

	task automatic test_commands();
		send_cmd(OP_RDREG, '0, '0, 5'd31);
		send_cmd(OP_RDMEM, 16'hFFFE);
		send_cmd(OP_LOAD, 16'hFFFE, 32'hFFFF_FFFF);
		send_cmd(OP_RDMEM, 16'hFFFF);
		send_cmd(OP_LOAD, 16'h0001, 32'h0000_0000);
		send_cmd(OP_RDMEM, 16'hFFFD);
		send_cmd(3'd5, 16'hFFFF, 32'hFFFF_FFFF, 5'd31);
		send_cmd(3'd7);
		send_cmd(OP_STEP);
		send_cmd(OP_STEP);
		cfg_write(CFG_INIT_SP, 32'hFFFF_FFFF);
		send_cmd(OP_RESTART);
		send_cmd(OP_RDREG, '0, '0, 5'd2);
		cfg_write(CFG_STEP_LIMIT, 32'd0);
		send_cmd(OP_STEP);
		send_cmd(OP_STEP);
		cfg_write(CFG_STEP_LIMIT, 32'hFFFF_FFFF);
	endtask

	task automatic test_special_insns();
		logic [31:0] prog [$];
		prog = '{
			{12'hFFF, 5'd0, 3'd0, 5'd1, OPC_IMM},
			enc_r(FUNCT7_ALT, 5'd1, 5'd0, 3'd0, 5'd3),
			enc_r(FUNCT7_ALT, 5'd2, 5'd1, 3'd5, 5'd4),
			{7'h20, 5'd31, 5'd1, 3'd5, 5'd5, OPC_IMM},
			{12'd5, 5'd0, 3'd0, 5'd0, OPC_IMM},
			enc_i(12'd3, 5'd1, 3'd3, 5'd6, OPC_LOAD),
			enc_s(12'd0, 5'd1, 5'd0, 3'd3),
			enc_b(13'd8, 5'd0, 5'd0, 3'd2),
			enc_i(12'hFFF, 5'd1, 3'd1, 5'd7, OPC_LOAD),
			enc_s(12'h7FF, 5'd1, 5'd2, 3'd2),
			{12'd48, 5'd0, 3'd0, 5'd8, OPC_IMM},
			enc_i(12'd1, 5'd8, 3'd0, 5'd8, OPC_JALR),
			{12'h123, 5'd0, 3'd0, 5'd0, OPC_SYSTEM} | 32'h0010_0000,
			32'h0000_007F
		};
		load_program(prog);
		repeat (16) send_cmd(OP_STEP);
		send_cmd(OP_RDREG, '0, '0, 5'd8);
		prog = '{{12'd1, 5'd0, 3'd0, 5'd0, OPC_SYSTEM}};
		load_program(prog);
		repeat (2) send_cmd(OP_STEP);
	endtask

	task automatic test_random_programs();
		logic [31:0] prog [$];
		int n;
		while (sent < 800) begin
			case ($urandom_range(0, 5))
				0: cfg_write(CFG_INIT_SP, $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0);
				1: cfg_write(CFG_INIT_SP, $urandom);
				2: cfg_write(CFG_STEP_LIMIT, $urandom_range(0, 12));
				3: cfg_write(CFG_STEP_LIMIT, 32'hFFFF_FFFF);
				default: ;
			endcase
			prog.delete();
			n = $urandom_range(3, 20);
			repeat (n) prog.insert(prog.size(), rand_insn());
			load_program(prog);
			if ($urandom_range(0, 5) == 0)
				cfg_write(CFG_CODE_BYTES, $urandom_range(0, 1) ? 32'd65536 : 32'($urandom_range(0, 100)));
			repeat ($urandom_range(10, 40)) begin
				case ($urandom_range(0, 19))
					0: send_cmd(OP_RDREG, '0, '0, 5'($urandom));
					1: send_cmd(OP_RDMEM, 16'($urandom));
					2: send_cmd(3'($urandom), 16'($urandom), $urandom, 5'($urandom));
					default: send_cmd(OP_STEP);
				endcase
			end
		end
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		sent = 0;
		arst_n = 1'b0;
		start = 1'b0;
		op = OP_LOAD;
		mem_address = '0;
		write_data = '0;
		reg_index = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		foreach (mem_img[i]) mem_img[i] = '0;
		foreach (gpr[i]) gpr[i] = '0;
		pc_m = '0;
		steps_m = '0;
		halt_m = ST_RUN;
		code_bytes_m = '0;
		init_sp_m = '0;
		step_limit_m = 32'd1000000;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		while (busy) @(negedge clk);

		test_commands();
		test_special_insns();
		test_random_programs();

		wait_idle();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("rv32i_instruction_executor_top_test: PASS");
		else
			$display("rv32i_instruction_executor_top_test: FAIL");
		$finish;
	end

endmodule
